// File: src/bci_pkg.sv
// shared types and constants for the barycentric color interpolator
// no dependencies
`default_nettype none
package bci_pkg;
    localparam int unsigned CHAN_BITS = 8;
    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'd255;
endpackage
`default_nettype wire

// File: src/bci_front.sv
// front end: edge cross products, sub-areas and weighted channel sums
// depends on bci_pkg
`default_nettype none
module bci_front
    import bci_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned AREA_BITS  = 2 * COORD_BITS + 1,
    parameter int unsigned SUM_BITS   = AREA_BITS + 10
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [COORD_BITS-1:0]   ax, ay, bx, by, cx, cy, px, py,
    input  wire logic [23:0]             ca, cb, cc,
    input  wire logic                    adv,
    output logic                         out_valid,
    output logic [AREA_BITS-1:0]         w,
    output logic [SUM_BITS-1:0]          sr, sg, sb
);
    localparam int unsigned D = COORD_BITS + 1;
    localparam int unsigned P = 2 * D;
    localparam int unsigned C = P + 1;

    logic v1_reg, v2_reg;
    logic signed [P-1:0] m_reg [8];
    logic [23:0] c1a_reg, c1b_reg, c1c_reg;
    logic [AREA_BITS-1:0] w_reg, wa_reg, wb_reg, wc_reg;
    logic [23:0] c2a_reg, c2b_reg, c2c_reg;
    logic v3_reg;
    logic [SUM_BITS-1:0] sr_reg, sg_reg, sb_reg;
    logic [AREA_BITS-1:0] w3_reg;

    function automatic logic signed [D-1:0] df(input logic [COORD_BITS-1:0] p,
                                               input logic [COORD_BITS-1:0] q);
        df = $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic logic [AREA_BITS-1:0] ab(input logic signed [P-1:0] m0,
                                                input logic signed [P-1:0] m1);
        logic signed [C-1:0] d;
        d = C'(m0) - C'(m1);
        ab = AREA_BITS'(d < 0 ? -d : d);
    endfunction

    function automatic logic [SUM_BITS-1:0] bl(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c,
                                               input logic [AREA_BITS-1:0] x,
                                               input logic [AREA_BITS-1:0] y,
                                               input logic [AREA_BITS-1:0] z);
        bl = SUM_BITS'(a) * SUM_BITS'(x) + SUM_BITS'(b) * SUM_BITS'(y)
           + SUM_BITS'(c) * SUM_BITS'(z);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0] <= df(bx, ax) * df(cy, ay);
            m_reg[1] <= df(cx, ax) * df(by, ay);
            m_reg[2] <= df(bx, px) * df(cy, py);
            m_reg[3] <= df(cx, px) * df(by, py);
            m_reg[4] <= df(cx, px) * df(ay, py);
            m_reg[5] <= df(ax, px) * df(cy, py);
            m_reg[6] <= df(ax, px) * df(by, py);
            m_reg[7] <= df(bx, px) * df(ay, py);
            c1a_reg <= ca;
            c1b_reg <= cb;
            c1c_reg <= cc;
            w_reg  <= ab(m_reg[0], m_reg[1]);
            wa_reg <= ab(m_reg[2], m_reg[3]);
            wb_reg <= ab(m_reg[4], m_reg[5]);
            wc_reg <= ab(m_reg[6], m_reg[7]);
            c2a_reg <= c1a_reg;
            c2b_reg <= c1b_reg;
            c2c_reg <= c1c_reg;
            sr_reg <= bl(c2a_reg[23:16], c2b_reg[23:16], c2c_reg[23:16], wa_reg, wb_reg, wc_reg);
            sg_reg <= bl(c2a_reg[15:8], c2b_reg[15:8], c2c_reg[15:8], wa_reg, wb_reg, wc_reg);
            sb_reg <= bl(c2a_reg[7:0], c2b_reg[7:0], c2c_reg[7:0], wa_reg, wb_reg, wc_reg);
            w3_reg <= w_reg;
        end
    end

    assign out_valid = v3_reg;
    assign w  = w3_reg;
    assign sr = sr_reg;
    assign sg = sg_reg;
    assign sb = sb_reg;
endmodule
`default_nettype wire

// File: src/bci_queue.sv
// short request queue between front and back ends
// no dependencies
`default_nettype none
module bci_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd,
    output logic                  empty,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic [WIDTH-1:0]      rdata
);
    localparam int unsigned AW = $clog2(DEPTH);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    assign rdata = mem[rp_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
endmodule
`default_nettype wire

// File: src/bci_back.sv
// back end: pipelined restoring divider, clamp and output register
// depends on bci_pkg
`default_nettype none
module bci_back
    import bci_pkg::*;
#(
    parameter int unsigned AREA_BITS = 21,
    parameter int unsigned SUM_BITS  = 31
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [AREA_BITS-1:0] w,
    input  wire logic [SUM_BITS-1:0]  sr, sg, sb,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                red, green, blue,
    output logic                      degenerate
);
    // quotient bits 8..0 computed, bit 8 set means clamp
    localparam int unsigned NS = 9;
    localparam int unsigned RB = AREA_BITS + 1;

    typedef struct packed {
        logic [SUM_BITS-1:0] n;
        logic [RB-1:0]       r;
        logic [NS-1:0]       q;
        logic                ovf;
    } lane_t;

    logic                 v_reg   [NS+1];
    logic [AREA_BITS-1:0] d_reg   [NS+1];
    lane_t                l_reg   [NS+1][3];
    logic                 ov_reg;
    logic [7:0]           r_reg, g_reg, b_reg;
    logic                 dg_reg;
    logic                 adv;

    function automatic lane_t init(input logic [SUM_BITS-1:0] s,
                                   input logic [AREA_BITS-1:0] d);
        lane_t t;
        t.n = s;
        t.r = RB'(s >> (NS - 1));
        t.q = '0;
        // high bits of quotient beyond bit 8 already nonzero -> clamp
        t.ovf = (s >> (NS - 1)) >= (SUM_BITS'(d) << 1);
        init = t;
    endfunction

    function automatic lane_t stepf(input lane_t t, input logic [AREA_BITS-1:0] d,
                                    input int unsigned k);
        lane_t o;
        logic [RB:0] x;
        o = t;
        if (RB'(t.r) >= {1'b0, d})
        begin
            o.q[NS-1-k] = 1'b1;
            x = {1'b0, t.r} - {2'b0, d};
        end
        else
            x = {1'b0, t.r};
        if (k < NS - 1)
            o.r = RB'({x[RB-2:0], t.n[NS-2-k]});
        else
            o.r = RB'(x);
        stepf = o;
    endfunction

    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NS; i++)
                v_reg[i] <= v_reg[i-1];
            ov_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= w;
            l_reg[0][0] <= init(sr, w);
            l_reg[0][1] <= init(sg, w);
            l_reg[0][2] <= init(sb, w);
            for (int i = 1; i <= NS; i++)
            begin
                d_reg[i] <= d_reg[i-1];
                for (int c = 0; c < 3; c++)
                    l_reg[i][c] <= stepf(l_reg[i-1][c], d_reg[i-1], i - 1);
            end
            dg_reg <= (d_reg[NS] == '0);
            r_reg <= (d_reg[NS] == '0) ? 8'd0 :
                     (l_reg[NS][0].ovf || l_reg[NS][0].q[NS-1]) ? CHAN_MAX : l_reg[NS][0].q[7:0];
            g_reg <= (d_reg[NS] == '0) ? 8'd0 :
                     (l_reg[NS][1].ovf || l_reg[NS][1].q[NS-1]) ? CHAN_MAX : l_reg[NS][1].q[7:0];
            b_reg <= (d_reg[NS] == '0) ? 8'd0 :
                     (l_reg[NS][2].ovf || l_reg[NS][2].q[NS-1]) ? CHAN_MAX : l_reg[NS][2].q[7:0];
        end
    end

    assign out_valid  = ov_reg;
    assign red        = r_reg;
    assign green      = g_reg;
    assign blue       = b_reg;
    assign degenerate = dg_reg;
endmodule
`default_nettype wire

// File: src/barycentric_color_interpolator.sv
// top level of the barycentric color interpolator
// depends on bci_pkg, bci_front, bci_queue, bci_back
`default_nettype none
// Takes one request per clock while input ready is high. A three-stage front
// end computes the triangle area, the three sub-areas and the weighted channel
// sums; a queue holds its results; a ten-stage divider pipeline and an output
// register divide and clamp. The pipelined divider sustains one request per
// cycle while the output is not stalled. An output stall freezes the divider,
// and input ready drops once the queue could not hold the requests still in
// the front end. Zero-area triangles give black with degenerate set.
module barycentric_color_interpolator
    import bci_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y, color_a, color_b, color_c, zero pad
    input  wire logic [((8*COORD_BITS+72+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // red, green, blue
    output logic [23:0] m_axis_tdata,
    // degenerate
    output logic      m_axis_tuser
);
    localparam int unsigned AREA_BITS = 2 * COORD_BITS + 1;
    localparam int unsigned SUM_BITS  = AREA_BITS + 10;
    localparam int unsigned QW = AREA_BITS + 3 * SUM_BITS;
    localparam int unsigned QD = 8;
    localparam int unsigned CB = COORD_BITS;

    logic f_valid, q_empty, q_rd, adv;
    logic [AREA_BITS-1:0] f_w;
    logic [SUM_BITS-1:0] f_r, f_g, f_b;
    logic [QW-1:0] q_out;
    logic [$clog2(QD+1)-1:0] q_cnt;
    logic b_ready;
    logic [2:0] inflight;
    logic [7:0] red, green, blue;

    // front stages in flight plus queued must fit the queue
    assign adv = 1'b1;
    assign s_axis_tready = (32'(q_cnt) + 32'(inflight) + 32'd1) <= 32'(QD);

    logic fv1_reg, fv2_reg, fv3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv1_reg <= 1'b0;
            fv2_reg <= 1'b0;
            fv3_reg <= 1'b0;
        end
        else
        begin
            fv1_reg <= s_axis_tvalid && s_axis_tready;
            fv2_reg <= fv1_reg;
            fv3_reg <= fv2_reg;
        end
    end

    logic [2:0] pend;
    assign pend = {2'b0, fv1_reg} + {2'b0, fv2_reg} + {2'b0, fv3_reg};

    bci_front #(.COORD_BITS(COORD_BITS), .AREA_BITS(AREA_BITS), .SUM_BITS(SUM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .ax(s_axis_tdata[0*CB +: CB]), .ay(s_axis_tdata[1*CB +: CB]),
        .bx(s_axis_tdata[2*CB +: CB]), .by(s_axis_tdata[3*CB +: CB]),
        .cx(s_axis_tdata[4*CB +: CB]), .cy(s_axis_tdata[5*CB +: CB]),
        .px(s_axis_tdata[6*CB +: CB]), .py(s_axis_tdata[7*CB +: CB]),
        .ca(s_axis_tdata[8*CB +: 24]), .cb(s_axis_tdata[8*CB+24 +: 24]),
        .cc(s_axis_tdata[8*CB+48 +: 24]),
        .adv(adv),
        .out_valid(f_valid), .w(f_w), .sr(f_r), .sg(f_g), .sb(f_b)
    );

    bci_queue #(.WIDTH(QW), .DEPTH(QD)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr(f_valid), .wdata({f_b, f_g, f_r, f_w}),
        .rd(q_rd), .empty(q_empty), .count(q_cnt), .rdata(q_out)
    );

    assign q_rd = !q_empty && b_ready;

    bci_back #(.AREA_BITS(AREA_BITS), .SUM_BITS(SUM_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_rd), .in_ready(b_ready),
        .w(q_out[AREA_BITS-1:0]),
        .sr(q_out[AREA_BITS +: SUM_BITS]),
        .sg(q_out[AREA_BITS+SUM_BITS +: SUM_BITS]),
        .sb(q_out[AREA_BITS+2*SUM_BITS +: SUM_BITS]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .red(red), .green(green), .blue(blue), .degenerate(m_axis_tuser)
    );

    assign m_axis_tdata = {blue, green, red};

    // note: pend counts requests still in the front end
    always_comb
    begin
        inflight = pend;
    end

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        32'(q_cnt) <= 32'(QD)) else $error("queue overflow");
    a_degen_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0) else $error("degenerate not black");
    a_front_valid: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid == fv3_reg) else $error("front valid mismatch");
endmodule
`default_nettype wire

// File: test/bci_checker.sv
// result checker for the barycentric color interpolator: predicts each request's color
// depends on bci_pkg for channel limits
module bci_checker
    import bci_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned IN_W = ((8*COORD_BITS+72+7)/8)*8
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    input  wire logic            s_axis_tready,
    input  wire logic [IN_W-1:0] s_axis_tdata,
    input  wire logic            m_axis_tvalid,
    input  wire logic            m_axis_tready,
    input  wire logic [23:0]     m_axis_tdata,
    input  wire logic            m_axis_tuser,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen,
    output int                   degenerate_seen
);
    logic [24:0] color_q[$];

    function automatic longint unsigned twice_area(longint x0, longint y0, longint x1,
                                                   longint y1, longint x2, longint y2);
        longint cr;
        cr = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
        return (cr < 0) ? -cr : cr;
    endfunction

    // result packed as red in the low byte, then green, then blue
    function automatic logic [24:0] shade(logic [IN_W-1:0] d);
        longint c[8];
        logic [23:0] col[3];
        longint unsigned w, wa, wb, wc, s;
        logic [23:0] rgb;
        for (int i = 0; i < 8; i++)
            c[i] = d[i*COORD_BITS +: COORD_BITS];
        for (int i = 0; i < 3; i++)
            col[i] = d[8*COORD_BITS + 24*i +: 24];
        w = twice_area(c[0], c[1], c[2], c[3], c[4], c[5]);
        if (w == 0)
            return {1'b1, 24'd0};
        wa = twice_area(c[6], c[7], c[2], c[3], c[4], c[5]);
        wb = twice_area(c[6], c[7], c[4], c[5], c[0], c[1]);
        wc = twice_area(c[6], c[7], c[0], c[1], c[2], c[3]);
        for (int k = 0; k < 3; k++)
        begin
            s = col[0][16-8*k +: 8] * wa + col[1][16-8*k +: 8] * wb
              + col[2][16-8*k +: 8] * wc;
            s = s / w;
            rgb[8*k +: 8] = (s > CHAN_MAX) ? CHAN_MAX : s[7:0];
        end
        return {1'b0, rgb};
    endfunction

    task automatic report(string what, logic [24:0] got, logic [24:0] want);
        $display("mismatch %s: got deg=%0d rgb=%06h, want deg=%0d rgb=%06h",
                 what, got[24], got[23:0], want[24], want[23:0]);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        degenerate_seen = 0;
    end

    assign pending = color_q.size();

    always @(posedge clk)
    begin
        logic [24:0] want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                color_q.insert(color_q.size(), shade(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser)
                    degenerate_seen++;
                if (color_q.size() == 0)
                    report("unexpected result", {m_axis_tuser, m_axis_tdata}, 25'd0);
                else
                begin
                    want = color_q.pop_front();
                    if (m_axis_tuser !== want[24])
                        report("degenerate", {m_axis_tuser, m_axis_tdata}, want);
                    else if (m_axis_tdata[7:0] !== want[7:0])
                        report("red", {m_axis_tuser, m_axis_tdata}, want);
                    else if (m_axis_tdata[15:8] !== want[15:8])
                        report("green", {m_axis_tuser, m_axis_tdata}, want);
                    else if (m_axis_tdata[23:16] !== want[23:16])
                        report("blue", {m_axis_tuser, m_axis_tdata}, want);
                end
            end
        end
    end
endmodule

// File: test/tb_barycentric_color_interpolator.sv
// stimulus and verdict for the barycentric color interpolator
// depends on barycentric_color_interpolator and bci_checker
module tb_barycentric_color_interpolator;
    localparam int unsigned CB = 10;
    localparam int unsigned IN_W = ((8*CB+72+7)/8)*8;
    localparam int unsigned CMAX = (1 << CB) - 1;
    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic m_axis_tuser;
    int fail_count, pending, results_seen, degenerate_seen;
    int cycles;
    bit hold_off;

    barycentric_color_interpolator #(.COORD_BITS(CB)) dut (.*);

    bci_checker #(.COORD_BITS(CB)) chk (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .fail_count, .pending, .results_seen, .degenerate_seen
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_barycentric_color_interpolator: errors");
                $finish;
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_axis_tready <= 0;
            else
            begin
                mode = (cycles / 300) % 3;
                if (mode == 0)
                    m_axis_tready <= 1;
                else if (mode == 1)
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                else
                    m_axis_tready <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 4))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [CB-1:0] rand_coord(int span);
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? CB'(CMAX) : '0;
        return CB'($urandom_range(0, span));
    endfunction

    function automatic logic [IN_W-1:0] pack_req(int c[8], logic [23:0] ca,
                                                 logic [23:0] cb, logic [23:0] cc);
        logic [IN_W-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++)
            d[i*CB +: CB] = CB'(c[i]);
        d[8*CB +: 72] = {cc, cb, ca};
        return d;
    endfunction

    task automatic send(logic [IN_W-1:0] d);
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic gap(int n);
        s_axis_tvalid <= 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic random_req();
        int c[8];
        int span;
        int base;
        span = ($urandom_range(0, 3) == 0) ? CMAX : $urandom_range(2, 60);
        base = $urandom_range(0, CMAX - span);
        for (int i = 0; i < 8; i++)
            c[i] = base + rand_coord(span) % (span + 1);
        case ($urandom_range(0, 9))
            0:
            begin
                // collinear vertices
                c[4] = c[2];
                c[5] = c[3];
            end
            1:
            begin
                // pixel on a vertex
                c[6] = c[0];
                c[7] = c[1];
            end
            2:
            begin
                // pixel at the centroid
                c[6] = (c[0] + c[2] + c[4]) / 3;
                c[7] = (c[1] + c[3] + c[5]) / 3;
            end
            default: ;
        endcase
        send(pack_req(c, rand_color(), rand_color(), rand_color()));
    endtask

    initial
    begin
        int c[8];
        int burst;
        rst_n = 0;
        hold_off = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, degenerate, outside pixel, vertex pixels
        c = '{0, 0, CMAX, 0, 0, CMAX, 0, 0};
        send(pack_req(c, 24'hFF0000, 24'h00FF00, 24'h0000FF));
        c = '{0, 0, CMAX, 0, 0, CMAX, CMAX, 0};
        send(pack_req(c, 24'hFF0000, 24'h00FF00, 24'h0000FF));
        c = '{0, 0, CMAX, 0, 0, CMAX, 0, CMAX};
        send(pack_req(c, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        c = '{0, 0, CMAX, 0, 0, CMAX, CMAX, CMAX};
        send(pack_req(c, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        c = '{0, 0, CMAX, 0, 0, CMAX, CMAX, CMAX};
        send(pack_req(c, 24'h000000, 24'h000000, 24'h000000));
        c = '{5, 5, 5, 5, 5, 5, 5, 5};
        send(pack_req(c, 24'hFFFFFF, 24'h123456, 24'h808080));
        c = '{0, 0, 512, 512, CMAX, CMAX, 3, 900};
        send(pack_req(c, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        c = '{CMAX, CMAX, 0, CMAX, CMAX, 0, 0, 0};
        send(pack_req(c, 24'hAA55AA, 24'h55AA55, 24'hFFFFFF));
        c = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0};
        send(pack_req(c, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        c = '{0, CMAX, CMAX, 0, 0, 0, 341, 341};
        send(pack_req(c, 24'h0F0F0F, 24'hF0F0F0, 24'h7F7F7F));
        c = '{1, 2, 3, 7, 9, 1, 4, 3};
        send(pack_req(c, 24'h010203, 24'hFEFDFC, 24'h808080));
        drain();

        // long receiver hold-off with sender pushing
        hold_off = 1;
        fork
            begin
                repeat (200) @(negedge clk);
                hold_off = 0;
            end
            repeat (60) random_req();
        join
        drain();

        for (int n = 0; n < 1650; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
                random_req();
            n += burst;
            if ($urandom_range(0, 2) == 0)
                gap($urandom_range(1, 8));
        end
        drain();
        s_axis_tvalid <= 0;
        repeat (40) @(negedge clk);

        $display("covered %0d results, %0d of them degenerate, in %0d cycles",
                 results_seen, degenerate_seen, cycles);
        if (fail_count == 0 && pending == 0)
            $display("tb_barycentric_color_interpolator: clean");
        else
            $display("tb_barycentric_color_interpolator: errors");
        $finish;
    end
endmodule
